// File: design/site_population_statistics_assert.svh
// assertion macros for the site population statistics block
`ifndef SITE_POPULATION_STATISTICS_ASSERT_SVH
`define SITE_POPULATION_STATISTICS_ASSERT_SVH

// condition holds in the same cycle as the trigger
`define SPS_ASSERT_SAME(label, trig, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |-> (cond)) \
        else $error("sps assertion failed");

// condition holds in the cycle after the trigger
`define SPS_ASSERT_NEXT(label, trig, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cond)) \
        else $error("sps assertion failed");

`endif

// File: design/sps_pkg.sv
// package: constants, types and helper functions of the site population statistics block
`default_nettype none

package sps_pkg;

    localparam int GENE_W      = 64;
    localparam int FLAG_W      = 10;
    localparam int CNT_W       = 17;
    localparam int IDX_W       = 4;
    localparam int NUM_CLASSES = 4;
    localparam int NUM_FLAGS   = 10;
    localparam int NUM_STATS   = 1 + NUM_CLASSES + NUM_FLAGS;
    localparam int CNT_MAX     = 131071;

    localparam int FRAME_SITES_MAX_DEF = 65536;

    // statistic slots
    localparam int STAT_LIVE   = 0;
    localparam int STAT_CLASS0 = 1;
    localparam int STAT_FLAG0  = STAT_CLASS0 + NUM_CLASSES;

    localparam logic [IDX_W-1:0] STAT_IDX_FIRST = IDX_W'(STAT_LIVE);
    localparam logic [IDX_W-1:0] STAT_IDX_LAST  = IDX_W'(NUM_STATS - 1);

    // class modes
    localparam logic MODE_QUARTER = 1'b0;
    localparam logic MODE_MOD4    = 1'b1;

    typedef logic [NUM_STATS-1:0][CNT_W-1:0] sps_stats_t;

    typedef struct packed {
        logic              alive;
        logic              last;
        logic [FLAG_W-1:0] flags;
        logic [GENE_W-1:0] gene;
    } sps_site_t;

    // population count as a six-level adder tree
    function automatic logic [6:0] popcount64(input logic [GENE_W-1:0] x);
        logic [1:0] l1 [32];
        logic [2:0] l2 [16];
        logic [3:0] l3 [8];
        logic [4:0] l4 [4];
        logic [5:0] l5 [2];
        for (int i = 0; i < 32; i++)
        begin
            l1[i] = {1'b0, x[2*i]} + {1'b0, x[2*i+1]};
        end
        for (int i = 0; i < 16; i++)
        begin
            l2[i] = {1'b0, l1[2*i]} + {1'b0, l1[2*i+1]};
        end
        for (int i = 0; i < 8; i++)
        begin
            l3[i] = {1'b0, l2[2*i]} + {1'b0, l2[2*i+1]};
        end
        for (int i = 0; i < 4; i++)
        begin
            l4[i] = {1'b0, l3[2*i]} + {1'b0, l3[2*i+1]};
        end
        for (int i = 0; i < 2; i++)
        begin
            l5[i] = {1'b0, l4[2*i]} + {1'b0, l4[2*i+1]};
        end
        return {1'b0, l5[0]} + {1'b0, l5[1]};
    endfunction

    // gene class from the popcount
    function automatic logic [1:0] gene_class(input logic mode, input logic [6:0] p);
        logic [1:0] cls;
        unique case (mode)
            MODE_MOD4:    cls = p[1:0];
            MODE_QUARTER: cls = p[6] ? 2'd3 : p[5:4]; // full word clamps to 63
            default:      cls = p[1:0];
        endcase
        return cls;
    endfunction

endpackage

`default_nettype wire

// File: design/sps_counters.sv
// saturating frame counters: live, per gene class and per flag bit
`default_nettype none

module sps_counters #(
    parameter int FRAME_SITES_MAX = sps_pkg::FRAME_SITES_MAX_DEF
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               class_mode,
    input  wire logic               go,
    input  wire sps_pkg::sps_site_t site,
    output sps_pkg::sps_stats_t     stats_next
);
    import sps_pkg::*;

    localparam int CAP_INT = (FRAME_SITES_MAX > CNT_MAX) ? CNT_MAX : FRAME_SITES_MAX;
    localparam logic [CNT_W-1:0] SAT_CAP = CNT_W'(CAP_INT);

    sps_stats_t cnt_reg;
    sps_stats_t cnt_next;
    logic [NUM_STATS-1:0] inc;
    logic [1:0] cls;

    always_comb
    begin
        cls = gene_class(class_mode, popcount64(site.gene));
        inc = '0;
        inc[STAT_LIVE] = site.alive;
        for (int c = 0; c < NUM_CLASSES; c++)
        begin
            inc[STAT_CLASS0 + c] = site.alive && (cls == 2'(c));
        end
        for (int f = 0; f < NUM_FLAGS; f++)
        begin
            inc[STAT_FLAG0 + f] = site.flags[f];
        end
        for (int k = 0; k < NUM_STATS; k++)
        begin
            stats_next[k] = (inc[k] && (cnt_reg[k] < SAT_CAP)) ? cnt_reg[k] + 1'b1
                                                                : cnt_reg[k];
        end
        // the frame closes on a last site: counters restart from zero
        if (go)
            cnt_next = site.last ? '0 : stats_next;
        else
            cnt_next = cnt_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cnt_reg <= '0;
        else
            cnt_reg <= cnt_next;
    end

endmodule

`default_nettype wire

// File: design/site_population_statistics.sv
// top level of the site population statistics block
//
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+-----------------------------------
//  in      | in        | in_valid / in_stall | alive, gene, step_flags, last_site
//  out     | out       | out_valid/out_stall | stat_index, stat_value, last_stat
//  cfg     | in        | cfg_we             | cfg_data (class_mode)
//
// one site per cycle while in_stall is low: a site is registered, then counted
// a last site hands its frame's 15 statistics to an output shift register,
// which sends one per cycle while out_stall is low; a second last site waits
// in the input register while the previous frame's statistics still drain
// reset clears the counters and control at once, no clearing pass
`default_nettype none
`include "site_population_statistics_assert.svh"

module site_population_statistics #(
    parameter int FRAME_SITES_MAX = sps_pkg::FRAME_SITES_MAX_DEF
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       cfg_we,
    input  wire logic                       cfg_data,
    input  wire logic                       in_valid,
    output logic                            in_stall,
    input  wire logic                       alive,
    input  wire logic [sps_pkg::GENE_W-1:0] gene,
    input  wire logic [sps_pkg::FLAG_W-1:0] step_flags,
    input  wire logic                       last_site,
    output logic                            out_valid,
    input  wire logic                       out_stall,
    output logic [sps_pkg::IDX_W-1:0]       stat_index,
    output logic [sps_pkg::CNT_W-1:0]       stat_value,
    output logic                            last_stat
);
    import sps_pkg::*;

    localparam int CAP_INT = (FRAME_SITES_MAX > CNT_MAX) ? CNT_MAX : FRAME_SITES_MAX;
    localparam logic [CNT_W-1:0] SAT_CAP = CNT_W'(CAP_INT);

    logic             class_mode_reg;
    logic             s1_valid_reg, s1_valid_next;
    sps_site_t        s1_site_reg;
    logic             out_busy_reg, out_busy_next;
    logic [IDX_W-1:0] out_idx_reg, out_idx_next;
    sps_stats_t       snap_reg, snap_next;
    sps_stats_t       stats_next;

    logic in_xfer, out_xfer, snap_free, s1_go, snap_load;

    assign out_xfer  = out_busy_reg && !out_stall;
    assign snap_free = !out_busy_reg || (out_xfer && (out_idx_reg == STAT_IDX_LAST));
    assign s1_go     = s1_valid_reg && (!s1_site_reg.last || snap_free);
    assign snap_load = s1_go && s1_site_reg.last;
    assign in_stall  = s1_valid_reg && !s1_go;
    assign in_xfer   = in_valid && !in_stall;

    assign out_valid  = out_busy_reg;
    assign stat_index = out_idx_reg;
    assign stat_value = snap_reg[0];
    assign last_stat  = (out_idx_reg == STAT_IDX_LAST);

    sps_counters #(
        .FRAME_SITES_MAX (FRAME_SITES_MAX)
    ) u_counters (
        .clk        (clk),
        .rst_n      (rst_n),
        .class_mode (class_mode_reg),
        .go         (s1_go),
        .site       (s1_site_reg),
        .stats_next (stats_next)
    );

    always_comb
    begin
        s1_valid_next = in_xfer ? 1'b1 : (s1_go ? 1'b0 : s1_valid_reg);

        priority if (snap_load)
        begin
            out_busy_next = 1'b1;
            out_idx_next  = STAT_IDX_FIRST;
            snap_next     = stats_next;
        end
        else if (out_xfer)
        begin
            out_busy_next = (out_idx_reg != STAT_IDX_LAST);
            out_idx_next  = out_idx_reg + 1'b1;
            // shift the next statistic to the head
            for (int k = 0; k < NUM_STATS - 1; k++)
            begin
                snap_next[k] = snap_reg[k+1];
            end
            snap_next[NUM_STATS-1] = '0;
        end
        else
        begin
            out_busy_next = out_busy_reg;
            out_idx_next  = out_idx_reg;
            snap_next     = snap_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            class_mode_reg <= MODE_QUARTER;
            s1_valid_reg   <= 1'b0;
            out_busy_reg   <= 1'b0;
            out_idx_reg    <= STAT_IDX_FIRST;
        end
        else
        begin
            if (cfg_we)
                class_mode_reg <= cfg_data;
            s1_valid_reg <= s1_valid_next;
            out_busy_reg <= out_busy_next;
            out_idx_reg  <= out_idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            s1_site_reg.alive <= alive;
            s1_site_reg.last  <= last_site;
            s1_site_reg.flags <= step_flags;
            s1_site_reg.gene  <= gene;
        end
        snap_reg <= snap_next;
    end

    // statistics of a frame go out in index order without gaps in numbering
    `SPS_ASSERT_NEXT(a_idx_step, out_valid && !out_stall && !last_stat,
        out_valid && (stat_index == $past(stat_index) + 1'b1))
    // after the final statistic the next frame starts at index zero
    `SPS_ASSERT_NEXT(a_frame_restart, out_valid && !out_stall && last_stat,
        !out_valid || (stat_index == STAT_IDX_FIRST))
    // the input waits only behind a frame that is still draining
    `SPS_ASSERT_SAME(a_stall_cause, in_stall, out_valid)
    // counts never pass the saturation cap
    `SPS_ASSERT_SAME(a_value_cap, out_valid, stat_value <= SAT_CAP)

endmodule

`default_nettype wire
